// File: rtl/core/chft_pkg.sv
`timescale 1ns / 1ps
package chft_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_EVAL  = 2'd2;
  typedef logic signed [15:0] coord_t;
  typedef logic signed [23:0] ocoord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;
endpackage

// File: rtl/core/convex_hull_facet_test.sv
`timescale 1ns / 1ps
// Channel  | Ports                         | Transfer
// input    | start, busy, in_*             | start high while busy low
// result   | out_valid, out_*              | out_valid high, one cycle
// config   | cfg_we, cfg_wdata             | cfg_we high
// Clear, load and unused items finish in the accepting cycle. An evaluate with
// fewer than three points, or after the final triple, answers in the next cycle.
// Any other evaluate holds busy for three reads (A, B, C), three normal steps,
// a walk over every stored point, the scaling of nine coordinates and output.
// The result stands in the first cycle in which busy is low again.
// Reset (synchronous, rst_n low) empties the set; the receiver cannot stall.
module convex_hull_facet_test (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  chft_pkg::coord_t      in_point_x,
  input  chft_pkg::coord_t      in_point_y,
  input  chft_pkg::coord_t      in_point_z,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  output logic                  out_valid,
  output logic                  out_is_facet,
  output logic                  out_last_triple,
  output chft_pkg::ocoord_t     out_first_x,
  output chft_pkg::ocoord_t     out_first_y,
  output chft_pkg::ocoord_t     out_first_z,
  output chft_pkg::ocoord_t     out_second_x,
  output chft_pkg::ocoord_t     out_second_y,
  output chft_pkg::ocoord_t     out_second_z,
  output chft_pkg::ocoord_t     out_third_x,
  output chft_pkg::ocoord_t     out_third_y,
  output chft_pkg::ocoord_t     out_third_z
);
  import chft_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_RDC  = 4'd3;
  localparam logic [3:0] S_N0   = 4'd4;
  localparam logic [3:0] S_N1   = 4'd5;
  localparam logic [3:0] S_N2   = 4'd6;
  localparam logic [3:0] S_D0   = 4'd7;
  localparam logic [3:0] S_D1   = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_D3   = 4'd10;
  localparam logic [3:0] S_SC   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  point_t mem [MAX_POINTS];
  point_t rd_r;
  logic [IDX_W-1:0] raddr;

  logic [3:0]        state_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  ia_r, ib_r, ic_r, ip_r;
  logic              done_r;
  logic [15:0]       scale_r;
  point_t            a_r, b_r, c_r;
  logic signed [16:0] bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic signed [34:0] nx_r, ny_r, nz_r;
  logic signed [16:0] vx_r, vy_r, vz_r;
  logic signed [53:0] acc_r;
  logic [1:0]        prev_r;
  logic              good_r, skip_r, last_r;
  logic [3:0]        sc_r;
  ocoord_t           o_r [9];

  // Point memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (start && !busy && in_mode == MODE_LOAD && count_r < CNT_W'(MAX_POINTS))
      mem[count_r[IDX_W-1:0]] <= '{in_point_x, in_point_y, in_point_z};
    rd_r <= mem[raddr];
  end

  // Read address: A, B and C in turn, then the walk, one point ahead.
  always_comb begin
    case (state_r)
      S_IDLE:  raddr = ia_r;
      S_RDA:   raddr = ib_r;
      S_RDB:   raddr = ic_r;
      S_N2:    raddr = '0;
      S_D3:    raddr = ip_r + 1'b1;
      default: raddr = ip_r;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Shared multiplier: 17x35 for the dot product, 17x17 for the normal.
  logic signed [16:0] m_a;
  logic signed [34:0] m_b;
  logic signed [51:0] m_p;
  always_comb begin
    case (state_r)
      S_N0:    begin m_a = by_r; m_b = 35'(cz_r); end
      S_N1:    begin m_a = bz_r; m_b = 35'(cx_r); end
      S_N2:    begin m_a = bx_r; m_b = 35'(cy_r); end
      S_D1:    begin m_a = vx_r; m_b = nx_r; end
      S_D2:    begin m_a = vy_r; m_b = ny_r; end
      default: begin m_a = vz_r; m_b = nz_r; end
    endcase
    m_p = 52'(m_a) * 52'(m_b);
  end

  // Second product of each normal component.
  logic signed [51:0] m_q;
  always_comb begin
    case (state_r)
      S_N0:    m_q = 52'(bz_r) * 52'(cy_r);
      S_N1:    m_q = 52'(bx_r) * 52'(cz_r);
      default: m_q = 52'(by_r) * 52'(cx_r);
    endcase
  end

  // Scaling of one output coordinate per cycle, floor shift.
  coord_t sc_in;
  logic signed [32:0] sc_p;
  always_comb begin
    case (sc_r)
      4'd0: sc_in = a_r.x;  4'd1: sc_in = a_r.y;  4'd2: sc_in = a_r.z;
      4'd3: sc_in = b_r.x;  4'd4: sc_in = b_r.y;  4'd5: sc_in = b_r.z;
      4'd6: sc_in = c_r.x;  4'd7: sc_in = c_r.y;  default: sc_in = c_r.z;
    endcase
    sc_p = 33'(sc_in) * $signed({17'd0, scale_r});
  end

  logic [CNT_W-1:0] lm3;
  logic same_v;
  logic signed [53:0] dsum;
  assign lm3 = count_r - CNT_W'(3);
  assign same_v = (rd_r == a_r) || (rd_r == b_r) || (rd_r == c_r);
  assign dsum = acc_r + 54'(m_p);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; done_r <= 1'b0;
      ia_r <= IDX_W'(0); ib_r <= IDX_W'(1); ic_r <= IDX_W'(2);
      scale_r <= 16'd256; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) scale_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_mode == MODE_CLEAR) begin
              count_r <= '0; done_r <= 1'b0;
              ia_r <= IDX_W'(0); ib_r <= IDX_W'(1); ic_r <= IDX_W'(2);
            end else if (in_mode == MODE_LOAD) begin
              if (count_r < CNT_W'(MAX_POINTS)) count_r <= count_r + 1'b1;
            end else if (in_mode == MODE_EVAL) begin
              if (count_r < CNT_W'(3) || done_r) begin
                out_valid <= 1'b1; out_is_facet <= 1'b0; out_last_triple <= 1'b1;
                {out_first_x, out_first_y, out_first_z} <= '0;
                {out_second_x, out_second_y, out_second_z} <= '0;
                {out_third_x, out_third_y, out_third_z} <= '0;
              end else state_r <= S_RDA;
            end
          end
        end
        S_RDA: begin a_r <= rd_r; state_r <= S_RDB; end
        S_RDB: begin
          b_r <= rd_r;
          bx_r <= 17'(rd_r.x) - 17'(a_r.x);
          by_r <= 17'(rd_r.y) - 17'(a_r.y);
          bz_r <= 17'(rd_r.z) - 17'(a_r.z);
          state_r <= S_RDC;
        end
        S_RDC: begin
          c_r <= rd_r;
          cx_r <= 17'(rd_r.x) - 17'(a_r.x);
          cy_r <= 17'(rd_r.y) - 17'(a_r.y);
          cz_r <= 17'(rd_r.z) - 17'(a_r.z);
          state_r <= S_N0;
        end
        // Normal components, one per cycle.
        S_N0: begin nx_r <= 35'(m_p) - 35'(m_q); state_r <= S_N1; end
        S_N1: begin ny_r <= 35'(m_p) - 35'(m_q); state_r <= S_N2; end
        S_N2: begin
          nz_r <= 35'(m_p) - 35'(m_q);
          good_r <= 1'b1; prev_r <= 2'b00; ip_r <= '0;
          last_r <= ({1'b0, ia_r} == lm3) &&
                    ({1'b0, ib_r} == lm3 + 1'b1) &&
                    ({1'b0, ic_r} == lm3 + 2'd2);
          state_r <= S_D0;
        end
        // Walk: offset of the point from A, then three dot-product terms.
        S_D0: begin
          skip_r <= same_v;
          vx_r <= 17'(rd_r.x) - 17'(a_r.x);
          vy_r <= 17'(rd_r.y) - 17'(a_r.y);
          vz_r <= 17'(rd_r.z) - 17'(a_r.z);
          state_r <= S_D1;
        end
        S_D1: begin acc_r <= 54'(m_p); state_r <= S_D2; end
        S_D2: begin acc_r <= dsum; state_r <= S_D3; end
        S_D3: begin
          // Final term and sign vote.
          if (!skip_r && dsum != '0) begin
            if ((dsum < 0 && prev_r == 2'b01) || (dsum > 0 && prev_r == 2'b11))
              good_r <= 1'b0;
            else prev_r <= (dsum < 0) ? 2'b11 : 2'b01;
          end
          if ({1'b0, ip_r} == count_r - CNT_W'(1)) begin
            sc_r <= '0; state_r <= S_SC;
          end else begin
            ip_r <= ip_r + 1'b1; state_r <= S_D0;
          end
        end
        S_SC: begin
          o_r[sc_r] <= sc_p[31:8];
          if (sc_r == 4'd8) state_r <= S_OUT;
          sc_r <= sc_r + 1'b1;
        end
        // Result transfer and advance to the next triple.
        S_OUT: begin
          out_valid <= 1'b1; out_is_facet <= good_r; out_last_triple <= last_r;
          {out_first_x, out_first_y, out_first_z} <= {o_r[0], o_r[1], o_r[2]};
          {out_second_x, out_second_y, out_second_z} <= {o_r[3], o_r[4], o_r[5]};
          {out_third_x, out_third_y, out_third_z} <= {o_r[6], o_r[7], o_r[8]};
          if (last_r) done_r <= 1'b1;
          else if ((IDX_W+1)'(ic_r) + 1'b1 < (IDX_W+1)'(count_r)) ic_r <= ic_r + 1'b1;
          else if ((IDX_W+1)'(ib_r) + 2'd2 < (IDX_W+1)'(count_r)) begin
            ib_r <= ib_r + 1'b1; ic_r <= ib_r + 2'd2;
          end else begin
            ia_r <= ia_r + 1'b1; ib_r <= ia_r + 2'd2; ic_r <= ia_r + 2'd3;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/convex_hull_facet_checker.sv
`timescale 1ns / 1ps
module convex_hull_facet_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_mode,
  input  chft_pkg::coord_t  in_point_x,
  input  chft_pkg::coord_t  in_point_y,
  input  chft_pkg::coord_t  in_point_z,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              out_valid,
  input  logic              out_is_facet,
  input  logic              out_last_triple,
  input  chft_pkg::ocoord_t out_first_x,
  input  chft_pkg::ocoord_t out_first_y,
  input  chft_pkg::ocoord_t out_first_z,
  input  chft_pkg::ocoord_t out_second_x,
  input  chft_pkg::ocoord_t out_second_y,
  input  chft_pkg::ocoord_t out_second_z,
  input  chft_pkg::ocoord_t out_third_x,
  input  chft_pkg::ocoord_t out_third_y,
  input  chft_pkg::ocoord_t out_third_z,
  output int                fail_count,
  output int                facets_pending,
  output int                triples_seen,
  output int                facets_seen
);
  import chft_pkg::*;

  typedef struct {
    logic    facet;
    logic    last;
    ocoord_t coord[9];
  } triple_result_t;

  triple_result_t triple_q[$];

  // Shadow copy of the block's point set and enumeration state.
  point_t      hull_pts[MAX_POINTS];
  int          pt_count;
  int          idx_a, idx_b, idx_c;
  bit          enum_done;
  logic [15:0] scale_q88;

  string coord_name[9] = '{"first_x", "first_y", "first_z", "second_x", "second_y",
                           "second_z", "third_x", "third_y", "third_z"};

  assign facets_pending = triple_q.size();

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    fail_count++;
  endtask

  // Floor of coord * scale / 256, cut to the 24-bit output width.
  function automatic ocoord_t scale_coord(coord_t c);
    longint p;
    p = longint'(c) * longint'({1'b0, scale_q88});
    return ocoord_t'(p >>> 8);
  endfunction

  // Facet test of the current triple and advance of the enumeration.
  task automatic predict_triple();
    triple_result_t r;
    point_t         a, b, c, v;
    longint         bx, by, bz, cx, cy, cz, nx, ny, nz, d;
    int             prev_sgn, sgn;
    bit             last;
    r.facet = 1'b0;
    r.last  = 1'b1;
    foreach (r.coord[n]) r.coord[n] = '0;
    if (pt_count >= 3 && !enum_done) begin
      a  = hull_pts[idx_a];
      b  = hull_pts[idx_b];
      c  = hull_pts[idx_c];
      bx = longint'(b.x) - a.x; by = longint'(b.y) - a.y; bz = longint'(b.z) - a.z;
      cx = longint'(c.x) - a.x; cy = longint'(c.y) - a.y; cz = longint'(c.z) - a.z;
      nx = by * cz - bz * cy;
      ny = bz * cx - bx * cz;
      nz = bx * cy - by * cx;
      prev_sgn = 0;
      r.facet  = 1'b1;
      for (int p = 0; p < pt_count; p++) begin
        v = hull_pts[p];
        if (v == a || v == b || v == c) continue;
        d = (longint'(v.x) - a.x) * nx + (longint'(v.y) - a.y) * ny
          + (longint'(v.z) - a.z) * nz;
        if (d == 0) continue;
        sgn = (d > 0) ? 1 : -1;
        if (sgn + prev_sgn == 0) r.facet = 1'b0;
        else prev_sgn = sgn;
      end
      last = (idx_a == pt_count - 3) && (idx_b == pt_count - 2) && (idx_c == pt_count - 1);
      r.last = last;
      r.coord[0] = scale_coord(a.x); r.coord[1] = scale_coord(a.y);
      r.coord[2] = scale_coord(a.z); r.coord[3] = scale_coord(b.x);
      r.coord[4] = scale_coord(b.y); r.coord[5] = scale_coord(b.z);
      r.coord[6] = scale_coord(c.x); r.coord[7] = scale_coord(c.y);
      r.coord[8] = scale_coord(c.z);
      if (last) begin
        enum_done = 1'b1;
      end else begin
        idx_c++;
        if (idx_c >= pt_count) begin
          idx_b++;
          if (idx_b >= pt_count - 1) begin
            idx_a++;
            idx_b = idx_a + 1;
          end
          idx_c = idx_b + 1;
        end
      end
    end
    triple_q.push_back(r);
  endtask

  task automatic restart_enum();
    pt_count  = 0;
    idx_a     = 0;
    idx_b     = 1;
    idx_c     = 2;
    enum_done = 1'b0;
  endtask

  // Compare one result transfer against the oldest prediction.
  task automatic check_result();
    triple_result_t exp;
    ocoord_t        got[9];
    got = '{out_first_x, out_first_y, out_first_z, out_second_x, out_second_y,
            out_second_z, out_third_x, out_third_y, out_third_z};
    triples_seen++;
    if (out_is_facet) facets_seen++;
    if (triple_q.size() == 0) begin
      $display("[%0t] result transfer with no prediction waiting", $realtime);
      fail_count++;
      return;
    end
    exp = triple_q.pop_front();
    if (out_is_facet !== exp.facet) report_mismatch("is_facet", out_is_facet, exp.facet);
    if (out_last_triple !== exp.last) report_mismatch("last_triple", out_last_triple, exp.last);
    foreach (got[n]) begin
      if (got[n] !== exp.coord[n]) report_mismatch(coord_name[n], got[n], exp.coord[n]);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_enum();
      scale_q88 = 16'd256;
      triple_q.delete();
      fail_count   = 0;
      triples_seen = 0;
      facets_seen  = 0;
    end else begin
      if (cfg_we) scale_q88 = cfg_wdata;
      if (start && !busy) begin
        case (in_mode)
          MODE_CLEAR: restart_enum();
          MODE_LOAD: begin
            if (pt_count < MAX_POINTS) begin
              hull_pts[pt_count] = '{x: in_point_x, y: in_point_y, z: in_point_z};
              pt_count++;
            end
          end
          MODE_EVAL: predict_triple();
          default: ;
        endcase
      end
      if (out_valid) check_result();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import chft_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1450;
  localparam int NUM_BLOCKS = 6;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  coord_t      in_point_x, in_point_y, in_point_z;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        out_valid, out_is_facet, out_last_triple;
  ocoord_t     out_first_x, out_first_y, out_first_z;
  ocoord_t     out_second_x, out_second_y, out_second_z;
  ocoord_t     out_third_x, out_third_y, out_third_z;
  int          fail_count, facets_pending, triples_seen, facets_seen;

  int items_sent;
  int idle_pct;
  int stall_cycles;

  convex_hull_facet_test u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_mode(in_mode),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_is_facet(out_is_facet), .out_last_triple(out_last_triple),
    .out_first_x(out_first_x), .out_first_y(out_first_y), .out_first_z(out_first_z),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_second_z(out_second_z), .out_third_x(out_third_x),
    .out_third_y(out_third_y), .out_third_z(out_third_z)
  );

  convex_hull_facet_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_mode(in_mode),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_is_facet(out_is_facet), .out_last_triple(out_last_triple),
    .out_first_x(out_first_x), .out_first_y(out_first_y), .out_first_z(out_first_z),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_second_z(out_second_z), .out_third_x(out_third_x),
    .out_third_y(out_third_y), .out_third_z(out_third_z),
    .fail_count(fail_count), .facets_pending(facets_pending),
    .triples_seen(triples_seen), .facets_seen(facets_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", facets_pending);
      $display("convex_hull_facet_test test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One input transfer, preceded by a random gap. Start stays high between
  // back-to-back transfers.
  task automatic send_item(logic [1:0] mode, coord_t px, coord_t py, coord_t pz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= mode;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_op(logic [1:0] mode);
    send_item(mode, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Hold off until every prediction is matched and the block has settled.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (facets_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Coordinate of a given flavor: full range, small (many coplanar cases),
  // or one of -32768, 32767 and 0.
  function automatic coord_t pick_coord(int flavor);
    int pick;
    if (flavor == 0) return coord_t'($urandom);
    if (flavor == 1) return coord_t'($urandom_range(6)) - coord_t'(3);
    pick = $urandom_range(2);
    return (pick == 0) ? coord_t'(-32768) : (pick == 1) ? coord_t'(32767) : coord_t'(0);
  endfunction

  task automatic load_random_point();
    int flavor;
    flavor = ($urandom_range(9) < 5) ? 0 : ($urandom_range(9) < 8) ? 1 : 2;
    send_item(MODE_LOAD, pick_coord(flavor), pick_coord(flavor), pick_coord(flavor));
  endtask

  // A cleared set, a batch of loads, then a walk through its triples with a
  // little noise and an occasional late load.
  task automatic run_point_set();
    int n_pts, n_evals;
    send_op(MODE_CLEAR);
    if ($urandom_range(24) == 0) n_pts = $urandom_range(60, MAX_POINTS + 3);
    else n_pts = $urandom_range(2, 8);
    repeat (n_pts) load_random_point();
    if (n_pts > 8) n_evals = 12;
    else n_evals = (n_pts * (n_pts - 1) * (n_pts - 2)) / 6 + $urandom_range(0, 2);
    if (n_evals == 0) n_evals = 2;
    repeat (n_evals) begin
      if ($urandom_range(29) == 0) send_op(MODE_UNUSED);
      if ($urandom_range(14) == 0) load_random_point();
      send_op(MODE_EVAL);
    end
  endtask

  initial begin
    logic [15:0] scale_plan[NUM_BLOCKS];
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = MODE_CLEAR;
    in_point_x   = '0;
    in_point_y   = '0;
    in_point_z   = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    items_sent   = 0;
    idle_pct     = 18;
    scale_plan   = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'd256, 16'd384};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: too few points, extreme and collinear points, finished
    // enumeration, unused mode, then a tetrahedron with a duplicate and an
    // interior point.
    send_op(MODE_EVAL);
    send_item(MODE_LOAD, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(MODE_LOAD, 16'sd32767, 16'sd32767, 16'sd32767);
    send_op(MODE_EVAL);
    send_item(MODE_LOAD, 16'sd0, 16'sd0, 16'sd0);
    send_op(MODE_EVAL);
    send_op(MODE_EVAL);
    send_item(MODE_LOAD, 16'sd256, 16'sd0, 16'sd0);
    send_op(MODE_EVAL);
    send_op(MODE_UNUSED);
    send_op(MODE_CLEAR);
    send_item(MODE_LOAD, 16'sd0, 16'sd0, 16'sd0);
    send_item(MODE_LOAD, 16'sd512, 16'sd0, 16'sd0);
    send_item(MODE_LOAD, 16'sd0, 16'sd512, 16'sd0);
    send_item(MODE_LOAD, 16'sd0, 16'sd0, -16'sd512);
    send_item(MODE_LOAD, 16'sd512, 16'sd0, 16'sd0);
    send_item(MODE_LOAD, 16'sd64, 16'sd64, -16'sd64);
    repeat (8) send_op(MODE_EVAL);

    // Random blocks, each under its own scale factor; idling changes every
    // two blocks.
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      write_scale(scale_plan[blk]);
      idle_pct = (blk < 2) ? 18 : (blk < 4) ? 82 : 0;
      while (items_sent < (blk + 1) * ITEM_TARGET / NUM_BLOCKS) run_point_set();
    end

    drain();
    $display("covered %0d input transfers and %0d triple results (%0d facets)",
             items_sent, triples_seen, facets_seen);
    $display("scale factors 0, 1, 256, 384, 65535 and a random one, with three idle patterns");
    if (fail_count == 0) begin
      $display("convex_hull_facet_test test passed");
    end else begin
      $display("convex_hull_facet_test test failed");
    end
    $finish;
  end

endmodule

// File: convex_hull_facet_test.f
rtl/core/chft_pkg.sv
rtl/core/convex_hull_facet_test.sv
test/convex_hull_facet_checker.sv
test/tb.sv
